// ===== hw/rtl/rcr_pkg.sv =====
// Shared constants, types and pattern helpers for the modem result code recognizer.
package rcr_pkg;

	localparam int LINE_MAX_DEF = 128;
	localparam int NUM_PAT      = 8;
	localparam int PAT_MAX      = 11;
	localparam int PROG_W       = 4;
	localparam int CODE_W       = 4;
	localparam int LEN_W        = 7;
	localparam int NUM_DIGITS   = 9;

	localparam logic [CODE_W-1:0] CODE_OK          = 4'd0;
	localparam logic [CODE_W-1:0] CODE_ERROR       = 4'd1;
	localparam logic [CODE_W-1:0] CODE_CONNECT     = 4'd2;
	localparam logic [CODE_W-1:0] CODE_NO_CARRIER  = 4'd3;
	localparam logic [CODE_W-1:0] CODE_BUSY        = 4'd4;
	localparam logic [CODE_W-1:0] CODE_NO_DIALTONE = 4'd5;
	localparam logic [CODE_W-1:0] CODE_NO_ANSWER   = 4'd6;
	localparam logic [CODE_W-1:0] CODE_RING        = 4'd7;
	localparam logic [CODE_W-1:0] CODE_UNKNOWN     = 4'd8;
	localparam logic [CODE_W-1:0] CODE_TIMEOUT     = 4'd9;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_EIGHT = 8'h38;

	// Patterns in priority order; text is right-aligned in each word.
	localparam logic [PAT_MAX*8-1:0] PAT_STR [NUM_PAT] = '{
		"OK", "ERROR", "CONNECT", "NO CARRIER",
		"BUSY", "NO DIALTONE", "NO ANSWER", "RING"
	};
	localparam int PAT_LEN [NUM_PAT] = '{2, 5, 7, 10, 4, 11, 9, 4};
	localparam logic [CODE_W-1:0] PAT_CODE [NUM_PAT] = '{
		CODE_OK, CODE_ERROR, CODE_CONNECT, CODE_NO_CARRIER,
		CODE_BUSY, CODE_NO_DIALTONE, CODE_NO_ANSWER, CODE_RING
	};

	// Single digit codes, indexed by the digit '0' through '8'.
	localparam logic [CODE_W-1:0] NUM_CODE [NUM_DIGITS] = '{
		CODE_OK, CODE_CONNECT, CODE_RING, CODE_NO_CARRIER, CODE_ERROR,
		CODE_UNKNOWN, CODE_NO_DIALTONE, CODE_BUSY, CODE_NO_ANSWER
	};

	typedef struct packed {
		logic feed;
		logic clear;
	} match_ctrl_t;

	function automatic logic [7:0] pat_char(input int p, input int i);
		return PAT_STR[p][(PAT_LEN[p] - 1 - i) * 8 +: 8];
	endfunction

	// KMP step: longest prefix of pattern p that ends the matched text plus c.
	function automatic logic [PROG_W-1:0] next_prog(input int p,
			input logic [PROG_W-1:0] prog, input logic [7:0] c);
		logic [PROG_W-1:0] res;
		logic              ok;
		int                k;
		int                i;
		res = '0;
		for (k = 1; k <= PAT_MAX; k++) begin
			if (k <= PAT_LEN[p] && k <= int'(prog) + 1) begin
				ok = (pat_char(p, k - 1) == c);
				for (i = 0; i < PAT_MAX - 1; i++) begin
					if (i + 1 < k) begin
						if (pat_char(p, i) != pat_char(p, int'(prog) - (k - 1) + i))
							ok = 1'b0;
					end
				end
				if (ok)
					res = PROG_W'(k);
			end
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/rcr_matcher.sv =====
// One substring matcher: automaton position and sticky found flag for a pattern.
module rcr_matcher #(
	parameter int PAT_IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rcr_pkg::match_ctrl_t ctrl,
	input  logic [7:0]          ch,
	output logic                found_nxt
);

	logic [rcr_pkg::PROG_W-1:0] prog_q;
	logic [rcr_pkg::PROG_W-1:0] prog_step;
	logic                       found_q;
	logic                       step_en;
	logic                       hit;

	assign step_en   = ctrl.feed && !found_q;
	assign prog_step = rcr_pkg::next_prog(PAT_IDX, prog_q, ch);
	assign hit       = step_en && (int'(prog_step) >= rcr_pkg::PAT_LEN[PAT_IDX]);
	assign found_nxt = found_q || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q  <= '0;
			found_q <= 1'b0;
		end else if (ctrl.clear) begin
			prog_q  <= '0;
			found_q <= 1'b0;
		end else if (step_en) begin
			found_q <= hit;
			prog_q  <= hit ? '0 : prog_step;
		end
	end

endmodule

// ===== hw/rtl/rcr_decode.sv =====
// Result code selection: pattern priority, then single-digit numeric codes.
module rcr_decode (
	input  logic [rcr_pkg::NUM_PAT-1:0] found,
	input  logic [1:0]                  text_class,
	input  logic [7:0]                  first,
	output logic [rcr_pkg::CODE_W-1:0]  code
);

	logic [3:0] digit;
	logic       is_digit;
	logic       any_found;

	// low nibble of an ASCII digit is its value
	assign digit     = first[3:0];
	assign is_digit  = first inside {[rcr_pkg::CH_ZERO:rcr_pkg::CH_EIGHT]};
	assign any_found = |found;

	always_comb begin
		code = rcr_pkg::CODE_UNKNOWN;
		if (any_found) begin
			for (int p = rcr_pkg::NUM_PAT - 1; p >= 0; p--) begin
				if (found[p])
					code = rcr_pkg::PAT_CODE[p];
			end
		end else if (text_class == 2'd1 && is_digit) begin
			code = rcr_pkg::NUM_CODE[digit];
		end
	end

endmodule

// ===== hw/rtl/modem_result_code_recognizer.sv =====
// Top level of the modem result code recognizer.
// Takes one received byte or timeout event per transaction and reports one
// result code per completed line. A transaction is registered on entry and
// then handled from that input register: line state and the eight pattern matchers
// update together, and the result lands in an output register, so one
// transaction per cycle is sustained. While a result waits to be taken, bytes
// inside a line keep flowing; only a line-ending transaction stalls behind it.
// Leading CR/LF bytes are dropped; a line ends on CR/LF, on timeout, or when
// LINE_MAX-1 bytes are held. line_length saturates at 127.
module modem_result_code_recognizer #(
	parameter int LINE_MAX = rcr_pkg::LINE_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [7:0]                 rx_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [rcr_pkg::CODE_W-1:0] result_code,
	output logic [rcr_pkg::LEN_W-1:0]  line_length
);

	localparam int CW = $clog2(LINE_MAX);
	localparam int WW = CW + rcr_pkg::LEN_W;

	// input stage
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;

	// line state
	logic [CW-1:0] cnt_q;
	logic [7:0]    first_q;
	logic [1:0]    tlc_q;
	logic          zero_q;

	// output register
	logic                       out_valid_q;
	logic [rcr_pkg::CODE_W-1:0] code_q;
	logic [rcr_pkg::LEN_W-1:0]  len_q;

	logic                       is_crlf;
	logic                       byte_evt;
	logic                       text_evt;
	logic [CW-1:0]              cnt_inc;
	logic                       emit;
	logic                       out_free;
	logic                       fire;
	logic [7:0]                 first_nxt;
	logic [1:0]                 tlc_nxt;
	logic [CW-1:0]              len_src;
	logic [WW-1:0]              len_wide;
	logic [rcr_pkg::LEN_W-1:0]  len_sat;
	logic [rcr_pkg::NUM_PAT-1:0] found_nxt;
	logic [rcr_pkg::CODE_W-1:0] dec_code;
	logic [rcr_pkg::CODE_W-1:0] code_nxt;
	rcr_pkg::match_ctrl_t       mctrl;

	assign is_crlf  = byte_s1 inside {rcr_pkg::CH_CR, rcr_pkg::CH_LF};
	assign byte_evt = !op_s1 && !is_crlf;
	assign text_evt = byte_evt && !zero_q && (byte_s1 != rcr_pkg::CH_NUL);
	assign cnt_inc  = cnt_q + CW'(1);

	always_comb begin
		if (op_s1)
			emit = 1'b1;
		else if (is_crlf)
			emit = (cnt_q != '0);
		else
			emit = (cnt_inc == CW'(LINE_MAX - 1));
	end

	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && (out_free || !emit);
	assign in_stall = valid_s1 && !fire;

	assign first_nxt = (byte_evt && cnt_q == '0) ? byte_s1 : first_q;
	assign tlc_nxt   = (text_evt && tlc_q != 2'd2) ? tlc_q + 2'd1 : tlc_q;

	assign mctrl.feed  = fire && text_evt;
	assign mctrl.clear = fire && emit;

	for (genvar p = 0; p < rcr_pkg::NUM_PAT; p++) begin : g_match
		rcr_matcher #(
			.PAT_IDX(p)
		) u_matcher (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (mctrl),
			.ch       (byte_s1),
			.found_nxt(found_nxt[p])
		);
	end

	rcr_decode u_decode (
		.found     (found_nxt),
		.text_class(tlc_nxt),
		.first     (first_nxt),
		.code      (dec_code)
	);

	assign len_src  = byte_evt ? cnt_inc : cnt_q;
	assign len_wide = WW'(len_src);
	assign len_sat  = (len_wide > WW'(127)) ? 7'd127 : len_wide[rcr_pkg::LEN_W-1:0];
	assign code_nxt = (op_s1 && cnt_q == '0) ? rcr_pkg::CODE_TIMEOUT : dec_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= opcode;
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			first_q <= '0;
			tlc_q   <= '0;
			zero_q  <= 1'b0;
		end else if (fire) begin
			if (emit) begin
				cnt_q   <= '0;
				first_q <= '0;
				tlc_q   <= '0;
				zero_q  <= 1'b0;
			end else if (byte_evt) begin
				cnt_q   <= cnt_inc;
				first_q <= first_nxt;
				tlc_q   <= tlc_nxt;
				if (byte_s1 == rcr_pkg::CH_NUL)
					zero_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			code_q <= code_nxt;
			len_q  <= len_sat;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_code = code_q;
	assign line_length = len_q;

endmodule

// ===== tb/sv/modem_result_code_recognizer_tb.sv =====
// Testbench for the modem result code recognizer: directed table plus random lines.
`timescale 1ns / 100ps

module modem_result_code_recognizer_tb;
	import rcr_pkg::*;

	localparam int LINE_MAX     = LINE_MAX_DEF;
	localparam int RANDOM_ITEMS = 2000;
	localparam int DRAIN_EVERY  = 500;

	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	typedef struct packed {
		logic              op;
		logic [7:0]        ch;
		logic              typed;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} step_row_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} line_result_t;

	// Directed sequence; typed rows carry the result that the item must produce.
	localparam step_row_t DIRECTED [26] = '{
		'{OP_TIMEOUT, 8'hFF,    1'b1, CODE_TIMEOUT,     7'd0},
		'{OP_BYTE,    CH_CR,    1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    CH_LF,    1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    CH_ZERO,  1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    CH_CR,    1'b1, CODE_OK,          7'd1},
		'{OP_BYTE,    "5",      1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_TIMEOUT, 8'h00,    1'b1, CODE_UNKNOWN,     7'd1},
		'{OP_BYTE,    "O",      1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    "K",      1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    CH_LF,    1'b1, CODE_OK,          7'd2},
		'{OP_BYTE,    CH_NUL,   1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    "O",      1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    "K",      1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    CH_CR,    1'b1, CODE_UNKNOWN,     7'd3},
		'{OP_BYTE,    CH_EIGHT, 1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    CH_CR,    1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    8'hFF,    1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    CH_CR,    1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    "R",      1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    "I",      1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    "N",      1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    "G",      1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_TIMEOUT, 8'h5A,    1'b1, CODE_RING,        7'd4},
		'{OP_BYTE,    "7",      1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    CH_NUL,   1'b0, CODE_UNKNOWN,     7'd0},
		'{OP_BYTE,    CH_LF,    1'b0, CODE_UNKNOWN,     7'd0}
	};

	string pat_text [NUM_PAT] = '{
		"OK", "ERROR", "CONNECT", "NO CARRIER",
		"BUSY", "NO DIALTONE", "NO ANSWER", "RING"
	};
	logic [CODE_W-1:0] pat_result [NUM_PAT] = '{
		CODE_OK, CODE_ERROR, CODE_CONNECT, CODE_NO_CARRIER,
		CODE_BUSY, CODE_NO_DIALTONE, CODE_NO_ANSWER, CODE_RING
	};
	// Self-overlapping and near-miss text for the matcher fallback paths.
	string tricky_text [14] = '{
		"NO NO CARRIER", "OOK", "ERRERROR", "CONNECONNECT", "RIRING", "BUSBUSY",
		"NO DIALNO DIALTONE", "NO ANSNO ANSWER", "NO CARRNO CARRIER", "ERROERROR",
		"ok", "Ok", "BUSY!RING", "RINGOK"
	};

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic              opcode    = 1'b0;
	logic [7:0]        rx_byte   = 8'h00;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [CODE_W-1:0] result_code;
	logic [LEN_W-1:0]  line_length;

	// Line tracking for the expected result codes
	int           line_bytes;
	logic         nul_seen;
	logic [7:0]   line_text [$];
	line_result_t pending_codes [$];

	int bad_results;
	int items_sent;
	bit quiet;

	modem_result_code_recognizer #(
		.LINE_MAX(LINE_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_code(result_code),
		.line_length(line_length)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void flag_error(input string msg);
		bad_results++;
		if (bad_results <= 10)
			$display("%t: %s", $realtime, msg);
	endfunction

	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// Closes the current line: first pattern present in the text wins, then a
	// one-character text is read as a digit code.
	function automatic void classify_line(output logic [CODE_W-1:0] code,
			output logic [LEN_W-1:0] len);
		int  p;
		int  s;
		int  j;
		bit  hit;
		bit  same;
		code = CODE_UNKNOWN;
		hit  = 1'b0;
		for (p = 0; p < NUM_PAT && !hit; p++) begin
			for (s = 0; s + pat_text[p].len() <= line_text.size() && !hit; s++) begin
				same = 1'b1;
				for (j = 0; j < pat_text[p].len(); j++)
					if (line_text[s + j] != pat_text[p][j])
						same = 1'b0;
				if (same) begin
					hit  = 1'b1;
					code = pat_result[p];
				end
			end
		end
		if (!hit && line_text.size() == 1) begin
			case (line_text[0])
				"0":     code = CODE_OK;
				"1":     code = CODE_CONNECT;
				"2":     code = CODE_RING;
				"3":     code = CODE_NO_CARRIER;
				"4":     code = CODE_ERROR;
				"6":     code = CODE_NO_DIALTONE;
				"7":     code = CODE_BUSY;
				"8":     code = CODE_NO_ANSWER;
				default: code = CODE_UNKNOWN;
			endcase
		end
		len = (line_bytes > 127) ? LEN_W'(127) : LEN_W'(line_bytes);
		line_bytes = 0;
		nul_seen   = 1'b0;
		line_text.delete();
	endfunction

	function automatic void recognize_item(input logic op, input logic [7:0] ch,
			output bit got, output logic [CODE_W-1:0] code, output logic [LEN_W-1:0] len);
		got  = 1'b0;
		code = CODE_UNKNOWN;
		len  = '0;
		if (op == OP_TIMEOUT) begin
			got = 1'b1;
			if (line_bytes == 0)
				code = CODE_TIMEOUT;
			else
				classify_line(code, len);
			return;
		end
		if (ch == CH_CR || ch == CH_LF) begin
			if (line_bytes != 0) begin
				got = 1'b1;
				classify_line(code, len);
			end
			return;
		end
		line_bytes++;
		// text stops feeding the matchers at the first NUL
		if (!nul_seen) begin
			if (ch == CH_NUL)
				nul_seen = 1'b1;
			else
				line_text.push_back(ch);
		end
		if (line_bytes >= LINE_MAX - 1) begin
			got = 1'b1;
			classify_line(code, len);
		end
	endfunction

	task automatic send_item(input logic op, input logic [7:0] ch, input logic typed,
			input logic [CODE_W-1:0] tcode, input logic [LEN_W-1:0] tlen);
		bit                got;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		line_result_t      want;
		int                gap;
		in_valid <= 1'b1;
		opcode   <= op;
		rx_byte  <= ch;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (!(op == OP_BYTE && (ch == CH_CR || ch == CH_LF) && line_bytes == 0))
			items_sent++;
		recognize_item(op, ch, got, code, len);
		if (typed) begin
			want.code = tcode;
			want.len  = tlen;
			pending_codes.push_back(want);
		end else if (got) begin
			want.code = code;
			want.len  = len;
			pending_codes.push_back(want);
		end
		gap = 0;
		if (!quiet && $urandom_range(0, 2) == 0)
			gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] ch);
		send_item(OP_BYTE, ch, 1'b0, CODE_UNKNOWN, '0);
	endtask

	// Sends a word, optionally with one character spoiled or the tail cut short.
	task automatic send_word(input string w, input int bad, input int cut);
		int         i;
		logic [7:0] ch;
		for (i = 0; i < w.len() - cut; i++) begin
			ch = w[i];
			if (i == bad) begin
				ch = 8'($urandom_range(32, 126));
				if (ch == w[i])
					ch = ch ^ 8'h20;
			end
			send_byte(ch);
		end
	endtask

	task automatic send_filler(input int n);
		repeat (n) send_byte(8'($urandom_range(32, 126)));
	endtask

	task automatic send_end();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			send_byte(CH_CR);
		else if (r < 6)
			send_byte(CH_LF);
		else if (r < 8) begin
			send_byte(CH_CR);
			send_byte(CH_LF);
		end else if (r < 9) begin
			send_byte(CH_LF);
			send_byte(CH_CR);
		end else
			send_item(OP_TIMEOUT, 8'($urandom), 1'b0, CODE_UNKNOWN, '0);
	endtask

	task automatic send_line();
		int r;
		int n;
		int p;
		r = $urandom_range(0, 99);
		p = $urandom_range(0, NUM_PAT - 1);
		if (r < 40) begin
			send_filler($urandom_range(0, 5));
			send_word(pat_text[p], -1, 0);
			if ($urandom_range(0, 3) == 0)
				send_word(pat_text[$urandom_range(0, NUM_PAT - 1)], -1, 0);
			send_filler($urandom_range(0, 4));
		end else if (r < 52) begin
			if ($urandom_range(0, 1) == 0)
				send_word(pat_text[p], $urandom_range(0, pat_text[p].len() - 1), 0);
			else
				send_word(pat_text[p], -1, 1);
		end else if (r < 64) begin
			if ($urandom_range(0, 3) == 0)
				send_byte(8'($urandom));
			else
				send_byte(8'($urandom_range(8'h30, 8'h39)));
			if ($urandom_range(0, 3) == 0) begin
				send_byte(CH_NUL);
				send_filler($urandom_range(0, 3));
			end
		end else if (r < 74) begin
			send_filler($urandom_range(0, 3));
			if ($urandom_range(0, 1) == 0)
				send_word(pat_text[$urandom_range(0, NUM_PAT - 1)], -1, 0);
			send_byte(CH_NUL);
			send_word(pat_text[p], -1, 0);
		end else if (r < 86) begin
			repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
		end else if (r < 92) begin
			send_word(tricky_text[$urandom_range(0, 13)], -1, 0);
		end else if (r < 95) begin
			repeat ($urandom_range(0, 3))
				send_byte(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
			send_item(OP_TIMEOUT, 8'($urandom), 1'b0, CODE_UNKNOWN, '0);
			return;
		end else if (r < 98) begin
			n = $urandom_range(100, 140);
			send_filler($urandom_range(0, n));
			send_word(pat_text[p], -1, 0);
			send_filler($urandom_range(0, 20));
			if ($urandom_range(0, 1) == 0)
				return;
		end else begin
			// right at the full-line boundary
			send_filler(LINE_MAX - 3 + $urandom_range(0, 3));
		end
		send_end();
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_codes.size() != 0);
	endtask

	// Result side: random stall runs, checks every accepted result.
	initial begin : result_side
		int stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (pending_codes.size() == 0)
					flag_error($sformatf("unexpected result code=%0d len=%0d",
						result_code, line_length));
				else if (result_code !== pending_codes[0].code ||
						line_length !== pending_codes[0].len)
					flag_error($sformatf("expected code=%0d len=%0d, got code=%0d len=%0d",
						pending_codes[0].code, pending_codes[0].len,
						result_code, line_length));
				if (pending_codes.size() != 0)
					void'(pending_codes.pop_front());
			end
			if (stall_left > 0)
				stall_left--;
			else if (!quiet && $urandom_range(0, 3) == 0)
				stall_left = idle_cycles();
			out_stall <= (stall_left > 0);
		end
	end

	initial begin : stimulus
		int line_no;
		int next_drain;
		int i;
		line_bytes  = 0;
		nul_seen    = 1'b0;
		bad_results = 0;
		items_sent  = 0;
		quiet       = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(DIRECTED); i++)
			send_item(DIRECTED[i].op, DIRECTED[i].ch, DIRECTED[i].typed,
				DIRECTED[i].code, DIRECTED[i].len);
		drain_results();

		line_no    = 0;
		next_drain = items_sent + DRAIN_EVERY;
		i          = items_sent + RANDOM_ITEMS;
		while (items_sent < i) begin
			quiet = (line_no % 40) < 6;
			send_line();
			line_no++;
			if (items_sent >= next_drain) begin
				drain_results();
				next_drain += DRAIN_EVERY;
			end
		end
		quiet = 1'b0;

		drain_results();
		repeat (10) @(posedge clk);
		if (bad_results == 0 && pending_codes.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : watchdog
		#50_000_000;
		$display("timeout with %0d results outstanding", pending_codes.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/rcr_pkg.sv
hw/rtl/rcr_matcher.sv
hw/rtl/rcr_decode.sv
hw/rtl/modem_result_code_recognizer.sv
tb/sv/modem_result_code_recognizer_tb.sv
